/* design/sv39ptw_pkg.sv */
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Shared widths, codes, types and helpers of the Sv39 page table walker.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

  localparam int WALK_LEVELS = 3;
  localparam int LVL_W       = (WALK_LEVELS > 2) ? $clog2(WALK_LEVELS) : 1;
  localparam int VA_BITS     = 12 + 9 * WALK_LEVELS;
  localparam int VADDR_W     = 64;
  localparam int PTE_W       = 64;
  localparam int PA_W        = 56;
  localparam int PPN_W       = 44;
  localparam int VPN_W       = 9;

  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(WALK_LEVELS - 1);

  // item kinds
  localparam logic REQ_XLATE = 1'b0;
  localparam logic REQ_PTE   = 1'b1;
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // access kinds
  localparam logic [1:0] ACC_FETCH = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_STORE = 2'd2;
  localparam logic [1:0] ACC_BAD   = 2'd3;

  // privilege
  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;

  typedef struct packed {
    logic               req_type;
    logic [VADDR_W-1:0] vaddr;
    logic [1:0]         access_type;
    logic [1:0]         cur_priv;
    logic               mprv;
    logic [1:0]         mpp;
    logic               sum;
    logic               mxr;
    logic [PTE_W-1:0]   pte;
  } ptw_item_t;

  typedef struct packed {
    logic            out_kind;
    logic [PA_W-1:0] mem_addr;
    logic [PA_W-1:0] paddr;
    logic            fault;
  } ptw_res_t;

  typedef struct packed {
    logic               walking;
    logic [LVL_W-1:0]   walk_level;
    logic [PPN_W-1:0]   table_ppn;
    logic [VA_BITS-1:0] saved_vaddr;
    logic [1:0]         saved_access;
    logic               saved_supervisor;
    logic               saved_sum;
    logic               saved_mxr;
  } ptw_state_t;

  // VPN slice of a virtual address for a given level
  function automatic logic [VPN_W-1:0] vpn_sel(input logic [VA_BITS-1:0] va,
                                               input logic [LVL_W-1:0] lvl);
    logic [VPN_W-1:0] idx;
    idx = '0;
    for (int l = 0; l < WALK_LEVELS; l++) begin
      if (lvl == LVL_W'(l)) begin
        idx = va[12 + 9*l +: VPN_W];
      end
    end
    return idx;
  endfunction

  // low PPN bits that a superpage at this level must leave zero
  function automatic logic [PPN_W-1:0] ppn_lo_mask(input logic [LVL_W-1:0] lvl);
    logic [PPN_W-1:0] m;
    m = '0;
    for (int i = 0; i < PPN_W; i++) begin
      m[i] = (i < 9 * int'(lvl));
    end
    return m;
  endfunction

  // page offset bits taken from the virtual address
  function automatic logic [PA_W-1:0] off_mask(input logic [LVL_W-1:0] lvl);
    logic [PA_W-1:0] m;
    m = '0;
    for (int i = 0; i < PA_W; i++) begin
      m[i] = (i < 12 + 9 * int'(lvl));
    end
    return m;
  endfunction

endpackage

/* design/sv39ptw_if.sv */
// ----------------------------------------------------------------------------
// sv39ptw_if
// Valid/ready channels of the walker: request/response in, result out, config.
// ----------------------------------------------------------------------------
interface sv39ptw_in_if import sv39ptw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [VADDR_W-1:0] vaddr;
  logic [1:0]         access_type;
  logic [1:0]         cur_priv;
  logic               mprv;
  logic [1:0]         mpp;
  logic               sum;
  logic               mxr;
  logic [PTE_W-1:0]   pte;

  modport source (output valid, req_type, vaddr, access_type, cur_priv, mprv, mpp,
                  sum, mxr, pte, input ready);
  modport sink   (input valid, req_type, vaddr, access_type, cur_priv, mprv, mpp,
                  sum, mxr, pte, output ready);
endinterface

interface sv39ptw_out_if import sv39ptw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            out_kind;
  logic [PA_W-1:0] mem_addr;
  logic [PA_W-1:0] paddr;
  logic            fault;

  modport source (output valid, out_kind, mem_addr, paddr, fault, input ready);
  modport sink   (input valid, out_kind, mem_addr, paddr, fault, output ready);
endinterface

interface sv39ptw_cfg_if import sv39ptw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PPN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/sv39ptw_step.sv */
// ----------------------------------------------------------------------------
// sv39ptw_step
// One walk step: checks a request or a PTE against the walk state and gives
// the result item (if any) and the next walk state.
// ----------------------------------------------------------------------------
module sv39ptw_step import sv39ptw_pkg::*; (
  input  ptw_item_t        item,
  input  ptw_state_t       st,
  input  logic [PPN_W-1:0] root_ppn,
  output logic             res_vld,
  output ptw_res_t         res,
  output ptw_state_t       st_nxt
);

  // request side
  logic [VADDR_W-VA_BITS-1:0] va_hi;
  logic                       canon;
  logic [1:0]                 eff_priv;
  logic                       req_fault;
  logic [VPN_W-1:0]           req_idx;

  // response side
  logic             pv, pr, pw, px, pu, pa, pd;
  logic [PPN_W-1:0] pppn;
  logic             rsv_bad;
  logic             is_ptr;
  logic             misalign;
  logic             leaf_fault;
  logic [PA_W-1:0]  omask;
  logic [PA_W-1:0]  leaf_pa;
  logic [VPN_W-1:0] ptr_idx;
  logic [LVL_W-1:0] lvl_dn;

  assign va_hi     = item.vaddr[VADDR_W-1:VA_BITS];
  assign canon     = (va_hi == '0) || (va_hi == '1);
  assign eff_priv  = ((item.access_type != ACC_FETCH) && item.mprv) ? item.mpp
                                                                     : item.cur_priv;
  assign req_fault = !canon || (eff_priv != PRIV_U && eff_priv != PRIV_S) ||
                     (item.access_type == ACC_BAD);
  assign req_idx   = vpn_sel(item.vaddr[VA_BITS-1:0], TOP_LVL);

  assign pv   = item.pte[0];
  assign pr   = item.pte[1];
  assign pw   = item.pte[2];
  assign px   = item.pte[3];
  assign pu   = item.pte[4];
  assign pa   = item.pte[6];
  assign pd   = item.pte[7];
  assign pppn = item.pte[53:10];

  assign rsv_bad  = (item.pte[PTE_W-1:54] != '0) || !pv || (pw && !pr);
  assign is_ptr   = !pr && !pw && !px;
  assign misalign = (pppn & ppn_lo_mask(st.walk_level)) != '0;
  assign lvl_dn   = st.walk_level - LVL_W'(1);
  assign ptr_idx  = vpn_sel(st.saved_vaddr, lvl_dn);

  always_comb begin
    if (st.saved_access == ACC_FETCH) begin
      leaf_fault = !px || (st.saved_supervisor && pu) ||
                   (!st.saved_supervisor && !pu) || !pa;
    end else begin
      leaf_fault = (st.saved_access == ACC_LOAD && !pr && !(px && st.saved_mxr)) ||
                   (st.saved_access == ACC_STORE && !pw) ||
                   (st.saved_supervisor && pu && !st.saved_sum) ||
                   (!st.saved_supervisor && !pu) ||
                   !pa || (st.saved_access == ACC_STORE && !pd);
    end
  end

  assign omask   = off_mask(st.walk_level);
  assign leaf_pa = ({pppn, 12'b0} & ~omask) | (PA_W'(st.saved_vaddr) & omask);

  always_comb begin
    st_nxt  = st;
    res_vld = 1'b0;
    res     = '0;
    if (item.req_type == REQ_XLATE) begin
      res_vld = 1'b1;
      if (req_fault) begin
        st_nxt.walking    = 1'b0;
        st_nxt.walk_level = TOP_LVL;
        res.out_kind      = KIND_DONE;
        res.fault         = 1'b1;
      end else begin
        st_nxt.walking          = 1'b1;
        st_nxt.walk_level       = TOP_LVL;
        st_nxt.table_ppn        = root_ppn;
        st_nxt.saved_vaddr      = item.vaddr[VA_BITS-1:0];
        st_nxt.saved_access     = item.access_type;
        st_nxt.saved_supervisor = eff_priv[0];
        st_nxt.saved_sum        = item.sum;
        st_nxt.saved_mxr        = item.mxr;
        res.out_kind            = KIND_READ;
        res.mem_addr            = {root_ppn, req_idx, 3'b000};
      end
    end else if (st.walking) begin
      res_vld = 1'b1;
      if (is_ptr && !rsv_bad && st.walk_level != '0) begin
        st_nxt.table_ppn  = pppn;
        st_nxt.walk_level = lvl_dn;
        res.out_kind      = KIND_READ;
        res.mem_addr      = {pppn, ptr_idx, 3'b000};
      end else begin
        st_nxt.walking    = 1'b0;
        st_nxt.walk_level = TOP_LVL;
        res.out_kind      = KIND_DONE;
        // pointer at the last level lands here as a fault too
        if (rsv_bad || is_ptr || misalign || leaf_fault) begin
          res.fault = 1'b1;
        end else begin
          res.paddr = leaf_pa;
        end
      end
    end
  end

endmodule

/* design/sv39_page_table_walker.sv */
// ----------------------------------------------------------------------------
// sv39_page_table_walker
// Sv39 page table walker: turns translate requests and PTE responses into
// PTE read addresses or finished translations.
// ----------------------------------------------------------------------------
// in_ch carries either a translate request (req_type 0) or the PTE that memory
// returned for the last read (req_type 1). Each item gives at most one result
// on out_ch: out_kind 0 asks for the PTE at mem_addr, out_kind 1 ends the walk
// with paddr or fault. A PTE while no walk runs gives no result; a request
// during a walk drops that walk.
// cfg_ch writes root_ppn (from satp); write it only while the walker is idle.
// Timing: an item is registered in the input register at acceptance and its
// result is registered in the output register once that register is free.
// One item per cycle is sustained while out_ch does not stall; all checks fit
// in the single evaluation stage.
// If out_ch stalls, one more item is still taken into the input register and
// in_ch.ready then drops until the result is taken.
// Reset (rst_n low, synchronous) empties both registers, leaves the walker
// idle at the top level and clears root_ppn.
// ----------------------------------------------------------------------------
module sv39_page_table_walker import sv39ptw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  sv39ptw_in_if.sink    in_ch,
  sv39ptw_out_if.source out_ch,
  sv39ptw_cfg_if.sink   cfg_ch
);

  logic             s0_vld_r;
  ptw_item_t        s0_item_r;
  logic             out_vld_r;
  ptw_res_t         out_r;
  ptw_state_t       st_r;
  logic [PPN_W-1:0] root_ppn_r;

  logic       out_free;
  logic       s0_go;
  logic       res_vld;
  ptw_res_t   res;
  ptw_state_t st_nxt;
  ptw_item_t  in_item;

  assign out_free    = !out_vld_r || out_ch.ready;
  assign s0_go       = s0_vld_r && out_free;
  assign in_ch.ready = !s0_vld_r || out_free;
  assign cfg_ch.ready = 1'b1;

  assign in_item.req_type    = in_ch.req_type;
  assign in_item.vaddr       = in_ch.vaddr;
  assign in_item.access_type = in_ch.access_type;
  assign in_item.cur_priv    = in_ch.cur_priv;
  assign in_item.mprv        = in_ch.mprv;
  assign in_item.mpp         = in_ch.mpp;
  assign in_item.sum         = in_ch.sum;
  assign in_item.mxr         = in_ch.mxr;
  assign in_item.pte         = in_ch.pte;

  sv39ptw_step u_step (
    .item     (s0_item_r),
    .st       (st_r),
    .root_ppn (root_ppn_r),
    .res_vld  (res_vld),
    .res      (res),
    .st_nxt   (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s0_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s0_go) begin
      out_vld_r <= res_vld;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_go && res_vld) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{walk_level: TOP_LVL, default: '0};
    end else if (s0_go) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_ppn_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      root_ppn_r <= cfg_ch.data;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.out_kind = out_r.out_kind;
  assign out_ch.mem_addr = out_r.mem_addr;
  assign out_ch.paddr    = out_r.paddr;
  assign out_ch.fault    = out_r.fault;

endmodule
